FILE: hdl/rtcep_pkg.sv
// Shared types, constants and helper functions for the clock-field to epoch-seconds pipeline.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package rtcep_pkg;

    localparam int unsigned RAW_W   = 8;
    localparam int unsigned BASE_W  = 14;
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned DAYS_W  = 24;
    localparam int unsigned DOY_W   = 10;
    localparam int unsigned TSEC_W  = 20;
    localparam int unsigned SECS_W  = 40;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = BASE_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_24_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTURY_PRESENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_YEAR       = 2'd3;

    localparam logic [BASE_W-1:0] BASE_YEAR_RST = 14'd2024;

    localparam int unsigned EPOCH_YEAR         = 1970;
    localparam int unsigned LEAPS_BEFORE_EPOCH = 477;   // leap years in 1..1969
    localparam int unsigned YEARS_PER_CENT     = 100;
    localparam int unsigned DAYS_PER_YEAR      = 365;
    localparam int unsigned HOURS_PER_DAY      = 24;
    localparam int unsigned SECS_PER_DAY       = 86400;
    localparam int unsigned SECS_PER_HOUR      = 3600;
    localparam int unsigned SECS_PER_MIN       = 60;
    localparam int unsigned HOUR_PM_OFFSET     = 12;

    // Reciprocal constants: x / 100 == (x * 5243) >> 19 for x below 2^15,
    // x / 24 == (x * 171) >> 12 for x below 140.
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int unsigned DIV100_SH  = 19;
    localparam logic [7:0]  DIV24_MUL  = 8'd171;
    localparam int unsigned DIV24_SH   = 12;

    typedef struct packed {
        logic              binary_mode;
        logic              hour_24_mode;
        logic              century_present;
        logic [BASE_W-1:0] base_year;
    } t_cfg;

    typedef struct packed {
        logic [RAW_W-1:0]  second;
        logic [RAW_W-1:0]  minute;
        logic [RAW_W-1:0]  hour;
        logic [RAW_W-1:0]  day;
        logic [RAW_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic              bad;
    } t_cal;

    typedef struct packed {
        t_cal              cal;
        logic [DAYS_W-1:0] days;
        logic [TSEC_W-1:0] tsec;
    } t_sum;

    function automatic logic [RAW_W-1:0] bcd_to_bin(input logic [RAW_W-1:0] b);
        return {4'd0, b[3:0]} + {1'b0, b[7:4], 3'd0} + {3'd0, b[7:4], 1'b0};
    endfunction

    // Days before the first of the month, non-leap year
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: hdl/rtcep_decode.sv
// Front of the pipeline: capture raw bytes, BCD decode, 12-to-24 hour fold, full year.
// Depends on rtcep_pkg.
module rtcep_decode (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rtcep_pkg::t_cfg         i_cfg,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_raw_second,
    input  logic [7:0]              i_raw_minute,
    input  logic [7:0]              i_raw_hour,
    input  logic [7:0]              i_raw_day,
    input  logic [7:0]              i_raw_month,
    input  logic [7:0]              i_raw_year,
    input  logic [7:0]              i_raw_century,
    output logic                    o_valid,
    input  logic                    i_stall,
    output rtcep_pkg::t_cal         o_cal
);

    // Stage 1: raw capture
    logic       r_s1_vld;
    logic [7:0] r_s1_sec, r_s1_min, r_s1_hr, r_s1_day, r_s1_mon, r_s1_yr, r_s1_cen;

    // Stage 2: decoded fields
    logic       r_s2_vld;
    logic [7:0] r_s2_sec, r_s2_min, r_s2_hdec, r_s2_day, r_s2_mon, r_s2_yr, r_s2_cen;
    logic       r_s2_pm;
    logic [7:0] r_s2_hv;
    logic [7:0] r_s2_base_q;
    logic [7:0] n_s2_sec, n_s2_min, n_s2_hdec, n_s2_day, n_s2_mon, n_s2_yr, n_s2_cen;
    logic [6:0] w_hour_bin;
    logic [26:0] w_base_prod;

    // Stage 3: year sum, hour quotient
    logic                               r_s3_vld;
    logic [7:0]                         r_s3_sec, r_s3_min, r_s3_hdec, r_s3_day, r_s3_mon;
    logic                               r_s3_pm;
    logic [7:0]                         r_s3_hv;
    logic [2:0]                         r_s3_hq;
    logic [rtcep_pkg::YEAR_W-1:0]       r_s3_ysum;
    logic                               r_s3_bad;
    logic [15:0]                        w_hv_prod;
    logic [14:0]                        n_s3_term;

    // Stage 4: final calendar fields
    logic            r_s4_vld;
    rtcep_pkg::t_cal r_s4_cal;
    rtcep_pkg::t_cal n_s4_cal;

    logic w_adv1, w_adv2, w_adv3, w_adv4;

    assign w_adv4  = !r_s4_vld || !i_stall;
    assign w_adv3  = !r_s3_vld || w_adv4;
    assign w_adv2  = !r_s2_vld || w_adv3;
    assign w_adv1  = !r_s1_vld || w_adv2;
    assign o_stall = !w_adv1;
    assign o_valid = r_s4_vld;
    assign o_cal   = r_s4_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (w_adv1) r_s1_vld <= i_valid;
            if (w_adv2) r_s2_vld <= r_s1_vld;
            if (w_adv3) r_s3_vld <= r_s2_vld;
            if (w_adv4) r_s4_vld <= r_s3_vld;
        end
    end

    // ---- stage 2 logic
    assign w_hour_bin  = {3'd0, r_s1_hr[3:0]} + {1'b0, r_s1_hr[6:4], 3'd0}
                       + {3'd0, r_s1_hr[6:4], 1'b0};
    assign w_base_prod = 27'(i_cfg.base_year) * 27'(rtcep_pkg::DIV100_MUL);

    always_comb begin
        if (i_cfg.binary_mode) begin
            n_s2_sec  = r_s1_sec;
            n_s2_min  = r_s1_min;
            n_s2_hdec = r_s1_hr;
            n_s2_day  = r_s1_day;
            n_s2_mon  = r_s1_mon;
            n_s2_yr   = r_s1_yr;
            n_s2_cen  = r_s1_cen;
        end else begin
            n_s2_sec  = rtcep_pkg::bcd_to_bin(r_s1_sec);
            n_s2_min  = rtcep_pkg::bcd_to_bin(r_s1_min);
            // keep the PM flag on top of the decoded hour
            n_s2_hdec = {r_s1_hr[7], w_hour_bin};
            n_s2_day  = rtcep_pkg::bcd_to_bin(r_s1_day);
            n_s2_mon  = rtcep_pkg::bcd_to_bin(r_s1_mon);
            n_s2_yr   = rtcep_pkg::bcd_to_bin(r_s1_yr);
            n_s2_cen  = rtcep_pkg::bcd_to_bin(r_s1_cen);
        end
    end

    // ---- stage 3 logic
    assign w_hv_prod = 16'(r_s2_hv) * 16'(rtcep_pkg::DIV24_MUL);
    assign n_s3_term = i_cfg.century_present
                     ? 15'(r_s2_cen) * 15'(rtcep_pkg::YEARS_PER_CENT)
                     : 15'(r_s2_base_q) * 15'(rtcep_pkg::YEARS_PER_CENT);

    // ---- stage 4 logic
    always_comb begin
        n_s4_cal.second = r_s3_sec;
        n_s4_cal.minute = r_s3_min;
        n_s4_cal.day    = r_s3_day;
        n_s4_cal.month  = r_s3_mon;
        n_s4_cal.bad    = r_s3_bad;
        if (r_s3_pm) begin
            n_s4_cal.hour = r_s3_hv
                          - 8'({5'd0, r_s3_hq} * 8'(rtcep_pkg::HOURS_PER_DAY));
        end else begin
            n_s4_cal.hour = r_s3_hdec;
        end
        // inferred century: move up one century when the year falls behind the base
        if (!i_cfg.century_present
            && (r_s3_ysum < rtcep_pkg::YEAR_W'(i_cfg.base_year))) begin
            n_s4_cal.year = r_s3_ysum + rtcep_pkg::YEAR_W'(rtcep_pkg::YEARS_PER_CENT);
        end else begin
            n_s4_cal.year = r_s3_ysum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_sec <= i_raw_second;
            r_s1_min <= i_raw_minute;
            r_s1_hr  <= i_raw_hour;
            r_s1_day <= i_raw_day;
            r_s1_mon <= i_raw_month;
            r_s1_yr  <= i_raw_year;
            r_s1_cen <= i_raw_century;
        end
        if (w_adv2) begin
            r_s2_sec    <= n_s2_sec;
            r_s2_min    <= n_s2_min;
            r_s2_hdec   <= n_s2_hdec;
            r_s2_day    <= n_s2_day;
            r_s2_mon    <= n_s2_mon;
            r_s2_yr     <= n_s2_yr;
            r_s2_cen    <= n_s2_cen;
            r_s2_pm     <= !i_cfg.hour_24_mode && n_s2_hdec[7];
            r_s2_hv     <= {1'b0, n_s2_hdec[6:0]} + 8'(rtcep_pkg::HOUR_PM_OFFSET);
            r_s2_base_q <= w_base_prod[rtcep_pkg::DIV100_SH +: 8];
        end
        if (w_adv3) begin
            r_s3_sec  <= r_s2_sec;
            r_s3_min  <= r_s2_min;
            r_s3_hdec <= r_s2_hdec;
            r_s3_day  <= r_s2_day;
            r_s3_mon  <= r_s2_mon;
            r_s3_pm   <= r_s2_pm;
            r_s3_hv   <= r_s2_hv;
            r_s3_hq   <= w_hv_prod[rtcep_pkg::DIV24_SH +: 3];
            r_s3_ysum <= rtcep_pkg::YEAR_W'(r_s2_yr) + rtcep_pkg::YEAR_W'(n_s3_term);
            r_s3_bad  <= (r_s2_mon == 8'd0) || (r_s2_mon > 8'd12) || (r_s2_day == 8'd0);
        end
        if (w_adv4) begin
            r_s4_cal <= n_s4_cal;
        end
    end

endmodule

FILE: hdl/rtcep_days.sv
// Middle of the pipeline: leap-year counts, day number since the epoch, time of day in seconds.
// Depends on rtcep_pkg.
module rtcep_days (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rtcep_pkg::t_cal i_cal,
    output logic            o_valid,
    input  logic            i_stall,
    output rtcep_pkg::t_sum o_sum
);

    localparam int unsigned DW = rtcep_pkg::DAYS_W;
    localparam int unsigned YW = rtcep_pkg::YEAR_W;

    // Stage 5: quotients by 100 and 400
    logic            r_s5_vld;
    rtcep_pkg::t_cal r_s5_cal;
    logic [8:0]      r_s5_q1;
    logic [8:0]      r_s5_qn;
    logic [6:0]      r_s5_qn4;
    logic [YW-3:0]   r_s5_n4;
    logic [YW-1:0]   r_s5_dy;
    logic            r_s5_gt;
    logic [YW-1:0]   w_n;
    logic [28:0]     w_q1_prod;
    logic [28:0]     w_qn_prod;
    logic [26:0]     w_qn4_prod;

    // Stage 6: whole-year days and day of year
    logic                       r_s6_vld;
    rtcep_pkg::t_cal            r_s6_cal;
    logic [DW-1:0]              r_s6_ydays;
    logic [rtcep_pkg::DOY_W-1:0] r_s6_doy;
    logic                       w_leap;
    logic [DW-1:0]              w_leaps;
    logic [YW-1:0]              w_cent_x100;

    // Stage 7: totals
    logic            r_s7_vld;
    rtcep_pkg::t_sum r_s7_sum;

    logic w_adv5, w_adv6, w_adv7;

    assign w_adv7  = !r_s7_vld || !i_stall;
    assign w_adv6  = !r_s6_vld || w_adv7;
    assign w_adv5  = !r_s5_vld || w_adv6;
    assign o_stall = !w_adv5;
    assign o_valid = r_s7_vld;
    assign o_sum   = r_s7_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else begin
            if (w_adv5) r_s5_vld <= i_valid;
            if (w_adv6) r_s6_vld <= r_s5_vld;
            if (w_adv7) r_s7_vld <= r_s6_vld;
        end
    end

    // ---- stage 5 logic: n is the last full year before this one
    assign w_n        = i_cal.year - YW'(1);
    assign w_q1_prod  = 29'(i_cal.year) * 29'(rtcep_pkg::DIV100_MUL);
    assign w_qn_prod  = 29'(w_n) * 29'(rtcep_pkg::DIV100_MUL);
    assign w_qn4_prod = 27'(w_n[YW-1:2]) * 27'(rtcep_pkg::DIV100_MUL);

    // ---- stage 6 logic
    assign w_cent_x100 = YW'(r_s5_q1) * YW'(rtcep_pkg::YEARS_PER_CENT);
    // a century year is leap only when its century count is a multiple of four
    assign w_leap = (r_s5_cal.year[1:0] == 2'd0)
                 && ((r_s5_cal.year != w_cent_x100) || (r_s5_q1[1:0] == 2'd0));
    assign w_leaps = DW'(r_s5_n4) - DW'(r_s5_qn) + DW'(r_s5_qn4)
                   - DW'(rtcep_pkg::LEAPS_BEFORE_EPOCH);

    always_ff @(posedge i_clk) begin
        if (w_adv5) begin
            r_s5_cal <= i_cal;
            r_s5_q1  <= w_q1_prod[rtcep_pkg::DIV100_SH +: 9];
            r_s5_qn  <= w_qn_prod[rtcep_pkg::DIV100_SH +: 9];
            r_s5_qn4 <= w_qn4_prod[rtcep_pkg::DIV100_SH +: 7];
            r_s5_n4  <= w_n[YW-1:2];
            r_s5_dy  <= i_cal.year - YW'(rtcep_pkg::EPOCH_YEAR);
            r_s5_gt  <= i_cal.year > YW'(rtcep_pkg::EPOCH_YEAR);
        end
        if (w_adv6) begin
            r_s6_cal <= r_s5_cal;
            // years up to the epoch contribute no days
            if (r_s5_gt) begin
                r_s6_ydays <= DW'(r_s5_dy) * DW'(rtcep_pkg::DAYS_PER_YEAR) + w_leaps;
            end else begin
                r_s6_ydays <= '0;
            end
            r_s6_doy <= rtcep_pkg::DOY_W'(rtcep_pkg::days_before_month(r_s5_cal.month[3:0]))
                      + rtcep_pkg::DOY_W'(w_leap && (r_s5_cal.month > 8'd2))
                      + rtcep_pkg::DOY_W'(r_s5_cal.day) - rtcep_pkg::DOY_W'(1);
        end
        if (w_adv7) begin
            r_s7_sum.cal  <= r_s6_cal;
            r_s7_sum.days <= r_s6_ydays + DW'(r_s6_doy);
            r_s7_sum.tsec <= rtcep_pkg::TSEC_W'(r_s6_cal.hour)
                               * rtcep_pkg::TSEC_W'(rtcep_pkg::SECS_PER_HOUR)
                           + rtcep_pkg::TSEC_W'(r_s6_cal.minute)
                               * rtcep_pkg::TSEC_W'(rtcep_pkg::SECS_PER_MIN)
                           + rtcep_pkg::TSEC_W'(r_s6_cal.second);
        end
    end

endmodule

FILE: hdl/rtc_fields_to_epoch_seconds_unit.sv
// Throughput: one transaction per cycle while i_out_stall is low; eight register stages (capture,
// decode, hour and year fold, division by 100/400 via reciprocal multiply, day counts, totals, seconds).
// Reset (i_rst_n low, synchronous) empties every stage and loads the configuration
// defaults: BCD fields, 12-hour clock, no century byte, base year 2024.
// Depends on rtcep_pkg, rtcep_decode and rtcep_days.
module rtc_fields_to_epoch_seconds_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rtcep_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtcep_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_raw_second,
    input  logic [7:0]                          i_raw_minute,
    input  logic [7:0]                          i_raw_hour,
    input  logic [7:0]                          i_raw_day,
    input  logic [7:0]                          i_raw_month,
    input  logic [7:0]                          i_raw_year,
    input  logic [7:0]                          i_raw_century,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [39:0]                         o_epoch_seconds,
    output logic [15:0]                         o_full_year,
    output logic [7:0]                          o_month_out,
    output logic [7:0]                          o_day_out,
    output logic [7:0]                          o_hour_out,
    output logic [7:0]                          o_minute_out,
    output logic [7:0]                          o_second_out,
    output logic                                o_bad_date
);

    rtcep_pkg::t_cfg r_cfg;

    logic            w_dec_valid, w_dec_stall;
    rtcep_pkg::t_cal w_dec_cal;
    logic            w_days_valid, w_days_stall;
    rtcep_pkg::t_sum w_days_sum;

    logic                          r_out_vld;
    logic [rtcep_pkg::SECS_W-1:0]  r_out_secs;
    rtcep_pkg::t_cal               r_out_cal;
    logic                          w_adv8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.binary_mode     <= 1'b0;
            r_cfg.hour_24_mode    <= 1'b0;
            r_cfg.century_present <= 1'b0;
            r_cfg.base_year       <= rtcep_pkg::BASE_YEAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtcep_pkg::CFG_BINARY_MODE:     r_cfg.binary_mode     <= i_cfg_data[0];
                rtcep_pkg::CFG_HOUR_24_MODE:    r_cfg.hour_24_mode    <= i_cfg_data[0];
                rtcep_pkg::CFG_CENTURY_PRESENT: r_cfg.century_present <= i_cfg_data[0];
                rtcep_pkg::CFG_BASE_YEAR:       r_cfg.base_year       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rtcep_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_raw_second  (i_raw_second),
        .i_raw_minute  (i_raw_minute),
        .i_raw_hour    (i_raw_hour),
        .i_raw_day     (i_raw_day),
        .i_raw_month   (i_raw_month),
        .i_raw_year    (i_raw_year),
        .i_raw_century (i_raw_century),
        .o_valid       (w_dec_valid),
        .i_stall       (w_dec_stall),
        .o_cal         (w_dec_cal)
    );

    rtcep_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .o_stall (w_dec_stall),
        .i_cal   (w_dec_cal),
        .o_valid (w_days_valid),
        .i_stall (w_days_stall),
        .o_sum   (w_days_sum)
    );

    // Output stage: hold the result while the consumer stalls
    assign w_adv8       = !r_out_vld || !i_out_stall;
    assign w_days_stall = !w_adv8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv8) begin
            r_out_vld <= w_days_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv8) begin
            r_out_cal <= w_days_sum.cal;
            // drop the seconds count on a bad date
            if (w_days_sum.cal.bad) begin
                r_out_secs <= '0;
            end else begin
                r_out_secs <= rtcep_pkg::SECS_W'(w_days_sum.days)
                                * rtcep_pkg::SECS_W'(rtcep_pkg::SECS_PER_DAY)
                            + rtcep_pkg::SECS_W'(w_days_sum.tsec);
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_epoch_seconds = r_out_secs;
    assign o_full_year     = r_out_cal.year;
    assign o_month_out     = r_out_cal.month;
    assign o_day_out       = r_out_cal.day;
    assign o_hour_out      = r_out_cal.hour;
    assign o_minute_out    = r_out_cal.minute;
    assign o_second_out    = r_out_cal.second;
    assign o_bad_date      = r_out_cal.bad;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rtc_fields_to_epoch_seconds_unit: directed snapshots, then
// random snapshots under changing register settings, with random idling on both channels.
// Depends on rtcep_pkg and the RTL under hdl/.
module tb;

    typedef struct packed {
        bit [7:0] sec;
        bit [7:0] min;
        bit [7:0] hr;
        bit [7:0] day;
        bit [7:0] mon;
        bit [7:0] yr;
        bit [7:0] cen;
    } t_snapshot;

    typedef struct packed {
        bit [39:0] epoch;
        bit [15:0] year;
        bit [7:0]  mon;
        bit [7:0]  day;
        bit [7:0]  hr;
        bit [7:0]  min;
        bit [7:0]  sec;
        bit        bad;
    } t_stamp;

    typedef struct packed {
        rtcep_pkg::t_cfg cfg;
        t_snapshot       snap;
        bit              typed;
        t_stamp          want;
    } t_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [rtcep_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rtcep_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [7:0]                       i_raw_second = '0;
    logic [7:0]                       i_raw_minute = '0;
    logic [7:0]                       i_raw_hour = '0;
    logic [7:0]                       i_raw_day = '0;
    logic [7:0]                       i_raw_month = '0;
    logic [7:0]                       i_raw_year = '0;
    logic [7:0]                       i_raw_century = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [39:0]                      o_epoch_seconds;
    logic [15:0]                      o_full_year;
    logic [7:0]                       o_month_out;
    logic [7:0]                       o_day_out;
    logic [7:0]                       o_hour_out;
    logic [7:0]                       o_minute_out;
    logic [7:0]                       o_second_out;
    logic                             o_bad_date;

    rtcep_pkg::t_cfg cfg_model;
    t_stamp          stamps_due[$];
    t_row            directed_rows[$];
    t_stamp          want;
    int unsigned     mismatches = 0;
    int unsigned     gap_max = 14;
    int unsigned     stall_max = 14;
    bit              hold_request = 1'b0;

    rtc_fields_to_epoch_seconds_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_raw_second    (i_raw_second),
        .i_raw_minute    (i_raw_minute),
        .i_raw_hour      (i_raw_hour),
        .i_raw_day       (i_raw_day),
        .i_raw_month     (i_raw_month),
        .i_raw_year      (i_raw_year),
        .i_raw_century   (i_raw_century),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_epoch_seconds (o_epoch_seconds),
        .o_full_year     (o_full_year),
        .o_month_out     (o_month_out),
        .o_day_out       (o_day_out),
        .o_hour_out      (o_hour_out),
        .o_minute_out    (o_minute_out),
        .o_second_out    (o_second_out),
        .o_bad_date      (o_bad_date)
    );

    always #5 i_clk = ~i_clk;

    function automatic rtcep_pkg::t_cfg make_cfg(bit bin, bit h24, bit cent,
                                                 int unsigned base);
        rtcep_pkg::t_cfg c;
        c.binary_mode     = bin;
        c.hour_24_mode    = h24;
        c.century_present = cent;
        c.base_year       = base[rtcep_pkg::BASE_W-1:0];
        return c;
    endfunction

    function automatic t_snapshot snap(bit [7:0] sec, bit [7:0] min, bit [7:0] hr,
                                       bit [7:0] day, bit [7:0] mon, bit [7:0] yr,
                                       bit [7:0] cen);
        t_snapshot s;
        s.sec = sec; s.min = min; s.hr = hr; s.day = day;
        s.mon = mon; s.yr = yr; s.cen = cen;
        return s;
    endfunction

    function automatic t_stamp stamp(longint unsigned epoch, int unsigned year,
                                     bit [7:0] mon, bit [7:0] day, bit [7:0] hr,
                                     bit [7:0] min, bit [7:0] sec, bit bad);
        t_stamp r;
        r.epoch = epoch[39:0]; r.year = year[15:0]; r.mon = mon; r.day = day;
        r.hr = hr; r.min = min; r.sec = sec; r.bad = bad;
        return r;
    endfunction

    function automatic int unsigned bcd_value(bit [7:0] b);
        int unsigned v;
        v = b[3:0] + b[7:4] * 10;
        return v;
    endfunction

    function automatic longint unsigned leaps_thru(longint unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Expected calendar fields and epoch seconds for one snapshot under cfg_model
    function automatic t_stamp stamp_of(t_snapshot s);
        int unsigned     sec, min, hr, day, mon, yr, cen, base;
        longint unsigned days, total;
        bit              leap_yr;
        t_stamp          r;
        sec = s.sec; min = s.min; hr = s.hr; day = s.day;
        mon = s.mon; yr = s.yr; cen = s.cen;
        base = cfg_model.base_year;
        if (!cfg_model.binary_mode) begin
            sec = bcd_value(s.sec);
            min = bcd_value(s.min);
            day = bcd_value(s.day);
            mon = bcd_value(s.mon);
            yr  = bcd_value(s.yr);
            cen = bcd_value(s.cen);
            // hour tens digit is three bits wide; the PM flag rides along
            hr  = s.hr[3:0] + s.hr[6:4] * 10;
            if (s.hr[7])
                hr = hr | 32'h80;
        end
        if (!cfg_model.hour_24_mode && hr[7])
            hr = ((hr & 32'h7F) + rtcep_pkg::HOUR_PM_OFFSET) % rtcep_pkg::HOURS_PER_DAY;
        if (cfg_model.century_present) begin
            yr = yr + cen * 100;
        end else begin
            yr = yr + (base / 100) * 100;
            if (yr < base)
                yr = yr + 100;
        end
        r.bad = (mon == 0) || (mon > 12) || (day == 0);
        total = 0;
        if (!r.bad) begin
            days = 0;
            if (yr > rtcep_pkg::EPOCH_YEAR)
                days = 64'(yr - rtcep_pkg::EPOCH_YEAR) * 64'(rtcep_pkg::DAYS_PER_YEAR)
                     + leaps_thru(64'(yr - 1))
                     - leaps_thru(64'(rtcep_pkg::EPOCH_YEAR - 1));
            leap_yr = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            for (int m = 1; m < mon; m++)
                days += 64'((m == 2) ? (leap_yr ? 29 : 28)
                          : (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31);
            days += 64'(day - 1);
            total = days * 64'(rtcep_pkg::SECS_PER_DAY)
                  + 64'(hr) * 64'(rtcep_pkg::SECS_PER_HOUR)
                  + 64'(min) * 64'(rtcep_pkg::SECS_PER_MIN) + 64'(sec);
        end
        r.epoch = total[39:0];
        r.year  = yr[15:0];
        r.mon   = mon[7:0];
        r.day   = day[7:0];
        r.hr    = hr[7:0];
        r.min   = min[7:0];
        r.sec   = sec[7:0];
        return r;
    endfunction

    function automatic bit [7:0] reg_code(int unsigned v);
        bit [7:0] code;
        if (cfg_model.binary_mode)
            code = v[7:0];
        else
            code = 8'(((v / 10) << 4) | (v % 10));
        return code;
    endfunction

    // Mostly plausible dates in the current encoding; some bad dates and pure noise
    function automatic t_snapshot random_snapshot();
        t_snapshot   s;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            s = snap(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        end else begin
            s.sec = reg_code($urandom_range(0, 59));
            s.min = reg_code($urandom_range(0, 59));
            if (cfg_model.hour_24_mode)
                s.hr = reg_code($urandom_range(0, 23));
            else
                s.hr = reg_code($urandom_range(1, 12));
            if (!cfg_model.hour_24_mode || $urandom_range(0, 7) == 0)
                s.hr[7] = 1'($urandom_range(0, 1));
            s.day = reg_code($urandom_range(1, 31));
            s.mon = reg_code($urandom_range(1, 12));
            s.yr  = reg_code($urandom_range(0, 99));
            if ($urandom_range(0, 3) == 0)
                s.cen = reg_code($urandom_range(0, 99));
            else
                s.cen = reg_code($urandom_range(19, 21));
            if (pick < 27) begin
                case ($urandom_range(0, 2))
                    0:       s.mon = 8'd0;
                    1:       s.mon = reg_code($urandom_range(13, 99));
                    default: s.day = 8'd0;
                endcase
            end
        end
        return s;
    endfunction

    task automatic report(string msg);
        if (mismatches < 50)
            $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic write_reg(logic [rtcep_pkg::CFG_IDX_W-1:0] idx,
                             logic [rtcep_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_config(rtcep_pkg::t_cfg c);
        write_reg(rtcep_pkg::CFG_BINARY_MODE, rtcep_pkg::CFG_DATA_W'(c.binary_mode));
        write_reg(rtcep_pkg::CFG_HOUR_24_MODE, rtcep_pkg::CFG_DATA_W'(c.hour_24_mode));
        write_reg(rtcep_pkg::CFG_CENTURY_PRESENT,
                  rtcep_pkg::CFG_DATA_W'(c.century_present));
        write_reg(rtcep_pkg::CFG_BASE_YEAR, c.base_year);
        i_cfg_we  <= 1'b0;
        cfg_model = c;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle();
        i_in_valid <= 1'b0;
        while (stamps_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic deliver_snapshot(t_snapshot s, bit typed, t_stamp typed_stamp);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_raw_second  <= s.sec;
        i_raw_minute  <= s.min;
        i_raw_hour    <= s.hr;
        i_raw_day     <= s.day;
        i_raw_month   <= s.mon;
        i_raw_year    <= s.yr;
        i_raw_century <= s.cen;
        do @(posedge i_clk); while (o_in_stall);
        stamps_due.push_back(typed ? typed_stamp : stamp_of(s));
    endtask

    task automatic add_row(rtcep_pkg::t_cfg c, t_snapshot s, bit typed, t_stamp w);
        t_row r;
        r.cfg = c; r.snap = s; r.typed = typed; r.want = w;
        directed_rows.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (stamps_due.size() == 0) begin
                report("result transaction with nothing pending");
            end else begin
                want = stamps_due.pop_front();
                if (o_epoch_seconds !== want.epoch)
                    report($sformatf("epoch_seconds %0d, expected %0d",
                                     o_epoch_seconds, want.epoch));
                if (o_full_year !== want.year)
                    report($sformatf("full_year %0d, expected %0d", o_full_year, want.year));
                if (o_month_out !== want.mon)
                    report($sformatf("month_out %0d, expected %0d", o_month_out, want.mon));
                if (o_day_out !== want.day)
                    report($sformatf("day_out %0d, expected %0d", o_day_out, want.day));
                if (o_hour_out !== want.hr)
                    report($sformatf("hour_out %0d, expected %0d", o_hour_out, want.hr));
                if (o_minute_out !== want.min)
                    report($sformatf("minute_out %0d, expected %0d", o_minute_out, want.min));
                if (o_second_out !== want.sec)
                    report($sformatf("second_out %0d, expected %0d", o_second_out, want.sec));
                if (o_bad_date !== want.bad)
                    report($sformatf("bad_date %0d, expected %0d", o_bad_date, want.bad));
            end
        end
    end

    // Result side: stall for a random count before each transaction, or hold long on request
    initial begin : receiver
        int unsigned hold;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold = 300;
            end else begin
                hold = $urandom_range(0, stall_max);
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        rtcep_pkg::t_cfg d, next_cfg;
        t_row            r;
        int unsigned     pick;
        d = make_cfg(0, 0, 0, int'(rtcep_pkg::BASE_YEAR_RST));
        cfg_model = d;

        // reset defaults: BCD, 12-hour, base year 2024
        add_row(d, snap(0, 0, 0, 0, 0, 0, 0), 1, stamp(0, 2100, 0, 0, 0, 0, 0, 1));
        add_row(d, snap(0, 0, 0, 8'h01, 8'h01, 8'h24, 0), 1,
                stamp(64'd1704067200, 2024, 1, 1, 0, 0, 0, 0));
        add_row(d, snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 0), 1,
                stamp(64'd4102444799, 2099, 12, 31, 23, 59, 59, 0));
        add_row(d, snap(0, 0, 0, 8'h01, 8'h13, 8'h24, 0), 1,
                stamp(0, 2024, 13, 1, 0, 0, 0, 1));
        // 12 PM folds to hour 0, 1 PM to 13, 12 AM stays 12
        add_row(d, snap(0, 0, 8'h92, 8'h01, 8'h01, 8'h24, 0), 1,
                stamp(64'd1704067200, 2024, 1, 1, 0, 0, 0, 0));
        add_row(d, snap(0, 0, 8'h81, 8'h01, 8'h01, 8'h24, 0), 1,
                stamp(64'd1704114000, 2024, 1, 1, 13, 0, 0, 0));
        add_row(d, snap(0, 0, 8'h12, 8'h01, 8'h01, 8'h24, 0), 0, '0);
        add_row(d, snap(0, 0, 0, 8'h29, 8'h02, 8'h24, 0), 1,
                stamp(64'd1709164800, 2024, 2, 29, 0, 0, 0, 0));
        add_row(d, snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1,
                stamp(0, 2165, 165, 165, 1, 165, 165, 1));
        add_row(d, snap(8'h5A, 8'h3F, 8'h7F, 8'h3F, 8'h01, 8'h23, 8'h55), 0, '0);
        add_row(d, snap(8'h30, 8'h15, 8'h11, 8'h01, 8'h03, 8'h00, 8'hAA), 0, '0);
        // century byte in use, 24-hour clock keeps bit 7, years before 1970
        add_row(make_cfg(0, 1, 1, 2024), snap(0, 0, 0, 8'h01, 8'h01, 8'h70, 8'h19), 1,
                stamp(0, 1970, 1, 1, 0, 0, 0, 0));
        add_row(make_cfg(0, 1, 1, 2024),
                snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19), 1,
                stamp(64'd31535999, 1969, 12, 31, 23, 59, 59, 0));
        add_row(make_cfg(0, 1, 1, 2024), snap(0, 0, 8'h92, 8'h01, 8'h01, 0, 8'h20), 0, '0);
        add_row(make_cfg(0, 1, 1, 2024),
                snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99), 0, '0);
        add_row(make_cfg(0, 1, 1, 2024), snap(0, 0, 0, 8'h29, 8'h02, 0, 8'h20), 0, '0);
        // binary fields, lowest base year
        add_row(make_cfg(1, 0, 0, 1970), snap(255, 255, 255, 255, 255, 255, 255), 1,
                stamp(0, 2155, 255, 255, 19, 255, 255, 1));
        add_row(make_cfg(1, 0, 0, 1970), snap(0, 0, 8'h8B, 1, 1, 70, 0), 1,
                stamp(82800, 1970, 1, 1, 23, 0, 0, 0));
        add_row(make_cfg(1, 0, 0, 1970), snap(0, 0, 0, 1, 1, 69, 0), 0, '0);
        // binary with century byte, highest base year
        add_row(make_cfg(1, 1, 1, 9999), snap(59, 59, 23, 31, 12, 255, 255), 0, '0);
        add_row(make_cfg(1, 1, 1, 9999), snap(0, 0, 0, 0, 0, 0, 0), 1,
                stamp(0, 0, 0, 0, 0, 0, 0, 1));
        add_row(make_cfg(1, 1, 1, 9999), snap(0, 0, 255, 1, 1, 0, 0), 0, '0);
        // inferred century past the base year
        add_row(make_cfg(0, 0, 0, 9999), snap(0, 0, 0, 8'h01, 8'h01, 0, 0), 0, '0);
        add_row(make_cfg(0, 0, 0, 9999),
                snap(8'h59, 8'h59, 8'h11, 8'h28, 8'h02, 8'h99, 0), 0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            if (r.cfg != cfg_model) begin
                settle();
                load_config(r.cfg);
            end
            deliver_snapshot(r.snap, r.typed, r.want);
        end

        for (int phase = 0; phase < 12; phase++) begin
            settle();
            pick = $urandom_range(0, 3);
            next_cfg = make_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)),
                                pick == 0 ? 1970 : pick == 1 ? 9999
                                          : $urandom_range(1970, 9999));
            if (phase == 0)
                next_cfg = make_cfg(0, 0, 0, 1970);
            else if (phase == 1)
                next_cfg = make_cfg(1, 1, 1, 9999);
            load_config(next_cfg);
            gap_max   = (phase % 4 == 3 || phase == 2) ? 0 : 14;
            stall_max = (phase % 4 == 3) ? 0 : 14;
            // back up the pipeline: long result hold while transactions keep coming
            if (phase == 2)
                hold_request = 1'b1;
            repeat (150)
                deliver_snapshot(random_snapshot(), 1'b0, '0);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
